[rtl/dq_pkg.sv]
// Shared types and constants of the double-ended queue.
`default_nettype none
package dq_pkg;

	localparam int unsigned REQ_W    = 2;
	localparam int unsigned VALUE_W  = 32;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned COUNT_W  = 5;

	typedef enum logic [REQ_W-1:0] {
		REQ_PUSH_FRONT = 2'd0,
		REQ_PUSH_BACK  = 2'd1,
		REQ_POP_FRONT  = 2'd2,
		REQ_POP_BACK   = 2'd3
	} req_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic show;
	} cmd_t;

endpackage
`default_nettype wire

[rtl/double_ended_queue.sv]
// Top level of the bounded double-ended queue.
//
//   Channel   Handshake         Ports
//   request   start & !busy     req_type, push_value
//   result    done (strobe)     pop_value, status, entry_count
//
// Each request is accepted while start is high and busy is low; its result is
// shown for exactly one cycle, the cycle after acceptance; a new request may be
// accepted every cycle while busy is low. Popped words, status and count are
// registered. Busy is high in reset and clears on the first clock edge after it.
// The receiver cannot stall; every result must be taken in its strobe cycle.
`default_nettype none
module double_ended_queue #(
	parameter int unsigned DEPTH      = 16,
	parameter int unsigned DATA_WIDTH = 32
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic [dq_pkg::REQ_W-1:0]          req_type,
	input  wire logic signed [dq_pkg::VALUE_W-1:0] push_value,
	output logic                                   done,
	output logic signed [dq_pkg::VALUE_W-1:0]      pop_value,
	output logic [dq_pkg::STATUS_W-1:0]            status,
	output logic [dq_pkg::COUNT_W-1:0]             entry_count
);

	dq_pkg::cmd_t cmd;

	dq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	dq_datapath #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.req_type    (req_type),
		.push_value  (push_value),
		.pop_value   (pop_value),
		.status      (status),
		.entry_count (entry_count)
	);

endmodule
`default_nettype wire

[rtl/dq_ctrl.sv]
// Controller of the double-ended queue: request handshake and result strobe.
`default_nettype none
module dq_ctrl (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	output logic             done,
	output dq_pkg::cmd_t     cmd
);

	typedef enum logic [0:0] {
		S_IDLE = 1'b0,
		S_RESP = 1'b1
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   accept;

	// Busy is held high only while coming out of reset.
	assign accept = start & ~busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b1;
		end else begin
			busy_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					// A new request may arrive in the same cycle the result is shown.
					if (!accept) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy       = busy_q;
	assign done       = (state_q == S_RESP);
	assign cmd.accept = accept;
	assign cmd.show   = (state_q == S_RESP);

endmodule
`default_nettype wire

[rtl/dq_datapath.sv]
// Datapath of the double-ended queue: entry memory, pointers and result registers.
`default_nettype none
module dq_datapath #(
	parameter int unsigned DEPTH      = 16,
	parameter int unsigned DATA_WIDTH = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire dq_pkg::cmd_t                  cmd,
	input  wire logic [dq_pkg::REQ_W-1:0]      req_type,
	input  wire logic signed [dq_pkg::VALUE_W-1:0] push_value,
	output logic signed [dq_pkg::VALUE_W-1:0]  pop_value,
	output logic [dq_pkg::STATUS_W-1:0]        status,
	output logic [dq_pkg::COUNT_W-1:0]         entry_count
);

	localparam int unsigned IW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW  = $clog2(DEPTH + 1);
	localparam int unsigned SW  = CW + 1;
	localparam int unsigned PW  = (DATA_WIDTH < dq_pkg::VALUE_W) ? DATA_WIDTH : dq_pkg::VALUE_W;
	localparam int unsigned COW = (CW < dq_pkg::COUNT_W) ? CW : dq_pkg::COUNT_W;

	localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);
	localparam logic [SW-1:0] DEPTH_S  = SW'(DEPTH);
	localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);

	logic [DATA_WIDTH-1:0] mem_q [DEPTH];
	logic [DATA_WIDTH-1:0] rd_q;
	logic                  use_rd_q;
	logic [dq_pkg::STATUS_W-1:0] status_q;
	logic [IW-1:0]         front_q;
	logic [CW-1:0]         count_q;

	dq_pkg::req_t          kind;
	dq_pkg::status_t       st_nxt;
	logic                  full;
	logic                  empty;
	logic                  do_wr;
	logic                  do_rd;
	logic [IW-1:0]         slot;
	logic [IW-1:0]         front_nxt;
	logic [CW-1:0]         count_nxt;
	logic [IW-1:0]         front_dec;
	logic [IW-1:0]         front_inc;
	logic [SW-1:0]         sum_back;
	logic [SW-1:0]         sum_last;
	logic [IW-1:0]         slot_back;
	logic [IW-1:0]         slot_last;
	logic [DATA_WIDTH-1:0] wr_data;

	assign kind  = dq_pkg::req_t'(req_type);
	assign full  = (count_q == DEPTH_C);
	assign empty = (count_q == '0);

	// Circular index arithmetic; each sum stays below twice the depth where it is used.
	assign front_dec = (front_q == '0) ? LAST_IDX : front_q - IW'(1);
	assign front_inc = (front_q == LAST_IDX) ? '0 : front_q + IW'(1);
	assign sum_back  = SW'(front_q) + SW'(count_q);
	assign sum_last  = SW'(front_q) + SW'(count_q - CW'(1));
	assign slot_back = (sum_back >= DEPTH_S) ? IW'(sum_back - DEPTH_S) : IW'(sum_back);
	assign slot_last = (sum_last >= DEPTH_S) ? IW'(sum_last - DEPTH_S) : IW'(sum_last);

	always_comb begin
		wr_data = '0;
		wr_data[PW-1:0] = push_value[PW-1:0];
	end

	always_comb begin
		st_nxt    = dq_pkg::ST_OK;
		do_wr     = 1'b0;
		do_rd     = 1'b0;
		slot      = front_q;
		front_nxt = front_q;
		count_nxt = count_q;
		case (kind)
			dq_pkg::REQ_PUSH_FRONT: begin
				if (full) begin
					st_nxt = dq_pkg::ST_FULL;
				end else begin
					do_wr     = 1'b1;
					slot      = front_dec;
					front_nxt = front_dec;
					count_nxt = count_q + CW'(1);
				end
			end
			dq_pkg::REQ_PUSH_BACK: begin
				if (full) begin
					st_nxt = dq_pkg::ST_FULL;
				end else begin
					do_wr     = 1'b1;
					slot      = slot_back;
					count_nxt = count_q + CW'(1);
				end
			end
			dq_pkg::REQ_POP_FRONT: begin
				if (empty) begin
					st_nxt = dq_pkg::ST_EMPTY;
				end else begin
					do_rd     = 1'b1;
					slot      = front_q;
					front_nxt = front_inc;
					count_nxt = count_q - CW'(1);
				end
			end
			dq_pkg::REQ_POP_BACK: begin
				if (empty) begin
					st_nxt = dq_pkg::ST_EMPTY;
				end else begin
					do_rd     = 1'b1;
					slot      = slot_last;
					count_nxt = count_q - CW'(1);
				end
			end
			default: begin
				st_nxt = dq_pkg::ST_OK;
			end
		endcase
	end

	// Entry memory with a registered read port; the read register doubles as
	// the output register for popped words.
	always_ff @(posedge clk) begin
		if (cmd.accept && do_wr) begin
			mem_q[slot] <= wr_data;
		end
		if (cmd.accept && do_rd) begin
			rd_q <= mem_q[slot];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			status_q <= st_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q  <= '0;
			count_q  <= '0;
			use_rd_q <= 1'b0;
		end else if (cmd.accept) begin
			front_q  <= front_nxt;
			count_q  <= count_nxt;
			use_rd_q <= do_rd;
		end
	end

	always_comb begin
		pop_value = '0;
		if (cmd.show && use_rd_q) begin
			pop_value[PW-1:0] = rd_q[PW-1:0];
		end
	end

	always_comb begin
		entry_count = '0;
		entry_count[COW-1:0] = count_q[COW-1:0];
	end

	assign status = status_q;

endmodule
`default_nettype wire

[tb/sv/testbench.sv]
// Self-checking testbench for the bounded double-ended queue.
`timescale 1ns / 1ps
module testbench;

	localparam int unsigned DEQUE_DEPTH  = 16;
	localparam int unsigned RANDOM_ITEMS = 1950;
	localparam int unsigned STALL_LIMIT  = 1000;
	localparam int unsigned DRAIN_CYCLES = 4;

	typedef struct {
		logic signed [dq_pkg::VALUE_W-1:0] pop_value;
		dq_pkg::status_t                   status;
		logic [dq_pkg::COUNT_W-1:0]        count;
	} deque_outcome_t;

	typedef struct {
		dq_pkg::req_t                      kind;
		logic signed [dq_pkg::VALUE_W-1:0] word;
		bit                                typed;
		deque_outcome_t                    want;
	} stim_row_t;

	logic                               clk;
	logic                               arst_n;
	logic                               start;
	logic                               busy;
	logic [dq_pkg::REQ_W-1:0]           req_type;
	logic signed [dq_pkg::VALUE_W-1:0]  push_value;
	logic                               done;
	logic signed [dq_pkg::VALUE_W-1:0]  pop_value;
	logic [dq_pkg::STATUS_W-1:0]        status;
	logic [dq_pkg::COUNT_W-1:0]         entry_count;

	// Expectation typed into a directed row, travels with the request.
	bit                                 typed_valid;
	deque_outcome_t                     typed_want;

	// Predictor state.
	logic signed [dq_pkg::VALUE_W-1:0]  model_words [DEQUE_DEPTH];
	logic [3:0]                         model_head;
	logic [dq_pkg::COUNT_W-1:0]         model_fill;

	deque_outcome_t                     pending_outcomes [$];
	deque_outcome_t                     oldest;
	deque_outcome_t                     predicted;
	int unsigned                        fail_count;
	int unsigned                        quiet_cycles;
	stim_row_t                          directed_rows [$];

	double_ended_queue dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.req_type    (req_type),
		.push_value  (push_value),
		.done        (done),
		.pop_value   (pop_value),
		.status      (status),
		.entry_count (entry_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic deque_outcome_t apply_request(dq_pkg::req_t kind,
			logic signed [dq_pkg::VALUE_W-1:0] word);
		deque_outcome_t res;
		logic [3:0]     slot;
		res.pop_value = '0;
		res.status    = dq_pkg::ST_OK;
		case (kind)
			dq_pkg::REQ_PUSH_FRONT, dq_pkg::REQ_PUSH_BACK: begin
				if (model_fill == dq_pkg::COUNT_W'(DEQUE_DEPTH)) begin
					res.status = dq_pkg::ST_FULL;
				end else begin
					if (kind == dq_pkg::REQ_PUSH_FRONT) begin
						model_head = model_head - 4'd1;
						slot = model_head;
					end else begin
						slot = model_head + model_fill[3:0];
					end
					model_words[slot] = word;
					model_fill = model_fill + dq_pkg::COUNT_W'(1);
				end
			end
			default: begin
				if (model_fill == '0) begin
					res.status = dq_pkg::ST_EMPTY;
				end else begin
					if (kind == dq_pkg::REQ_POP_FRONT) begin
						slot = model_head;
						model_head = model_head + 4'd1;
					end else begin
						slot = model_head + model_fill[3:0] - 4'd1;
					end
					res.pop_value = model_words[slot];
					model_fill = model_fill - dq_pkg::COUNT_W'(1);
				end
			end
		endcase
		res.count = model_fill;
		return res;
	endfunction

	function automatic stim_row_t make_row(dq_pkg::req_t kind,
			logic signed [dq_pkg::VALUE_W-1:0] word, bit typed,
			logic signed [dq_pkg::VALUE_W-1:0] pop, dq_pkg::status_t st, int unsigned cnt);
		stim_row_t row;
		row.kind           = kind;
		row.word           = word;
		row.typed          = typed;
		row.want.pop_value = pop;
		row.want.status    = st;
		row.want.count     = dq_pkg::COUNT_W'(cnt);
		return row;
	endfunction

	// Request and result monitor, predictor and watchdog.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				if (pending_outcomes.size() == 0) begin
					$error("result with no request outstanding");
					fail_count++;
				end else begin
					oldest = pending_outcomes.pop_front();
					if (pop_value !== oldest.pop_value) begin
						$error("pop_value: expected %h, got %h", oldest.pop_value, pop_value);
						fail_count++;
					end
					if (status !== oldest.status) begin
						$error("status: expected %0d, got %0d", oldest.status, status);
						fail_count++;
					end
					if (entry_count !== oldest.count) begin
						$error("entry_count: expected %0d, got %0d", oldest.count,
							entry_count);
						fail_count++;
					end
				end
			end
			if (start && !busy) begin
				predicted = apply_request(dq_pkg::req_t'(req_type), push_value);
				pending_outcomes.push_back(typed_valid ? typed_want : predicted);
			end
		end
		if (done || (start && !busy)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	// Holds a request on the ports until the block takes it.
	task automatic send_request(dq_pkg::req_t kind, logic signed [dq_pkg::VALUE_W-1:0] word,
			bit typed, deque_outcome_t want);
		start       <= 1'b1;
		req_type    <= kind;
		push_value  <= word;
		typed_valid <= typed;
		typed_want  <= want;
		do @(posedge clk); while (busy);
	endtask

	task automatic idle_cycles(int unsigned n);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	initial begin
		stim_row_t                         row;
		deque_outcome_t                    none;
		logic signed [dq_pkg::VALUE_W-1:0] word;
		dq_pkg::req_t                      kind;
		int unsigned                       sent;
		int unsigned                       burst;
		int unsigned                       mode;
		int unsigned                       push_odds;
		bit                                steady;

		arst_n      <= 1'b0;
		start       <= 1'b0;
		req_type    <= dq_pkg::REQ_PUSH_FRONT;
		push_value  <= '0;
		typed_valid <= 1'b0;
		typed_want  <= '{'0, dq_pkg::ST_OK, '0};
		fail_count   = 0;
		quiet_cycles = 0;
		model_head   = '0;
		model_fill   = '0;
		none         = '{'0, dq_pkg::ST_OK, '0};

		// After reset, extremes through both ends, then fill to full and push past it.
		directed_rows.push_back(make_row(dq_pkg::REQ_POP_FRONT, 32'sh0, 1, 32'sh0,
			dq_pkg::ST_EMPTY, 0));
		directed_rows.push_back(make_row(dq_pkg::REQ_POP_BACK, 32'sh0, 1, 32'sh0,
			dq_pkg::ST_EMPTY, 0));
		directed_rows.push_back(make_row(dq_pkg::REQ_PUSH_FRONT, 32'sh8000_0000, 1, 32'sh0,
			dq_pkg::ST_OK, 1));
		directed_rows.push_back(make_row(dq_pkg::REQ_PUSH_BACK, 32'sh7fff_ffff, 1, 32'sh0,
			dq_pkg::ST_OK, 2));
		directed_rows.push_back(make_row(dq_pkg::REQ_POP_FRONT, 32'sh0, 1, 32'sh8000_0000,
			dq_pkg::ST_OK, 1));
		directed_rows.push_back(make_row(dq_pkg::REQ_POP_BACK, 32'sh0, 1, 32'sh7fff_ffff,
			dq_pkg::ST_OK, 0));
		directed_rows.push_back(make_row(dq_pkg::REQ_POP_FRONT, 32'shffff_ffff, 1, 32'sh0,
			dq_pkg::ST_EMPTY, 0));
		for (int i = 0; i < DEQUE_DEPTH; i++) begin
			directed_rows.push_back(make_row(
				i % 2 ? dq_pkg::REQ_PUSH_BACK : dq_pkg::REQ_PUSH_FRONT,
				i % 4 < 2 ? 32'sh5555_5555 ^ i : 32'shaaaa_aaaa ^ i, 0, 32'sh0,
				dq_pkg::ST_OK, 0));
		end
		directed_rows.push_back(make_row(dq_pkg::REQ_PUSH_BACK, 32'sh1234_5678, 1, 32'sh0,
			dq_pkg::ST_FULL, 16));
		directed_rows.push_back(make_row(dq_pkg::REQ_PUSH_FRONT, 32'shffff_ffff, 1, 32'sh0,
			dq_pkg::ST_FULL, 16));

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			send_request(row.kind, row.word, row.typed, row.want);
			idle_cycles(($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
		end

		// Random part: most bursts lean toward pushes or pops so the deque swings
		// between empty and full often.
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			mode   = $urandom_range(0, 2);
			burst  = $urandom_range(1, 48);
			steady = ($urandom_range(0, 2) == 0);
			push_odds = (mode == 0) ? 80 : (mode == 1) ? 20 : 50;
			for (int n = 0; n < burst && sent < RANDOM_ITEMS; n++) begin
				if ($urandom_range(0, 99) < push_odds)
					kind = $urandom_range(0, 1) ? dq_pkg::REQ_PUSH_BACK
						: dq_pkg::REQ_PUSH_FRONT;
				else
					kind = $urandom_range(0, 1) ? dq_pkg::REQ_POP_BACK
						: dq_pkg::REQ_POP_FRONT;
				case ($urandom_range(0, 11))
					0: word = 32'sh8000_0000;
					1: word = 32'sh7fff_ffff;
					2: word = 32'sh0;
					3: word = 32'shffff_ffff;
					default: word = $urandom;
				endcase
				send_request(kind, word, 1'b0, none);
				sent++;
				if (!steady && $urandom_range(0, 3) == 0)
					idle_cycles($urandom_range(1, 5));
			end
			idle_cycles($urandom_range(0, 12));
		end

		start <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

[files.f]
rtl/dq_pkg.sv
rtl/dq_ctrl.sv
rtl/dq_datapath.sv
rtl/double_ended_queue.sv
tb/sv/testbench.sv
